@@ rtl/gbn_pkg.sv @@
// Go-back-N sender package: frame descriptor type, window control struct,
// action codes and default sizes. No dependencies.
package gbn_pkg;

	localparam int WINDOW_DEPTH_DEF  = 4;
	localparam int PENDING_DEPTH_DEF = 16;

	localparam int SEQ_W   = 32;
	localparam int TAG_W   = 6;
	localparam int LEN_W   = 7;
	localparam int LIMIT_W = 3;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);

	localparam logic [1:0] ACT_SEND    = 2'd0;
	localparam logic [1:0] ACT_TIMEOUT = 2'd1;
	localparam logic [1:0] ACT_ACK     = 2'd2;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] len;
	} frame_t;

	// shift: every cell takes its upper neighbor (front frame leaves)
	// recirc: with shift, the top valid cell takes the front frame (rotate)
	// append: the first free cell loads the incoming frame
	typedef struct packed {
		logic shift;
		logic recirc;
		logic append;
	} win_ctrl_t;

endpackage

@@ rtl/gbn_cell.sv @@
// One slot of the outstanding window chain: a frame descriptor and a valid bit.
// Depends on gbn_pkg (frame_t, win_ctrl_t).
module gbn_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  gbn_pkg::win_ctrl_t ctrl,
	input  logic             prev_valid,
	input  logic             next_valid,
	input  gbn_pkg::frame_t  next_frame,
	input  gbn_pkg::frame_t  head_frame,
	input  gbn_pkg::frame_t  append_frame,
	output logic             valid,
	output gbn_pkg::frame_t  frame
);

	logic            valid_q;
	gbn_pkg::frame_t frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid | (ctrl.recirc & valid_q);
		end else if (ctrl.append && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			if (next_valid) begin
				frame_q <= next_frame;
			end else if (ctrl.recirc && valid_q) begin
				frame_q <= head_frame;
			end
		end else if (ctrl.append && !valid_q && prev_valid) begin
			frame_q <= append_frame;
		end
	end

	assign valid = valid_q;
	assign frame = frame_q;

endmodule

@@ rtl/gbn_pend_fifo.sv @@
// Pending frame queue: circular buffer memory with registered read port.
// Depends on gbn_pkg (frame_t).
module gbn_pend_fifo #(
	parameter int DEPTH = gbn_pkg::PENDING_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  gbn_pkg::frame_t            wr_data,
	input  logic                       rd_en,
	output gbn_pkg::frame_t            rd_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	gbn_pkg::frame_t mem [DEPTH];
	gbn_pkg::frame_t rd_data_q;
	logic [PW-1:0]   head_q;
	logic [PW-1:0]   tail_q;
	logic [NW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (rd_en) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_data = rd_data_q;
	assign count   = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> count_q != NW'(DEPTH))
		else $error("pending queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> count_q != '0)
		else $error("pending queue read while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(DEPTH))
		else $error("pending count beyond depth");

endmodule

@@ rtl/go_back_n_sender_core.sv @@
// Go-back-N ARQ sender core: sequencer, window cell chain and pending queue.
// Depends on gbn_pkg, gbn_cell and gbn_pend_fifo.
//
// One input transaction is taken at a time; in_stall stays high until every
// transmit command it causes has been loaded into the output register. A
// send goes to the refill state, which moves frames into the window through
// the emit state one by one, and ends in the drop state when it is refused
// with no frame to move; an ack first retires frames in the retire state,
// then refills; a timeout walks the outstanding frames, which leave the window
// chain front first while the chain rotates. Each refilled frame passes the
// refill and emit states because the pending queue memory has a registered
// read. Output stalls lengthen these sequences. Unused input transactions
// (invalid action, timeout on an empty window) leave the sequencer idle.
module go_back_n_sender_core #(
	parameter int WINDOW_DEPTH  = gbn_pkg::WINDOW_DEPTH_DEF,
	parameter int PENDING_DEPTH = gbn_pkg::PENDING_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [gbn_pkg::LIMIT_W-1:0]  cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic [gbn_pkg::SEQ_W-1:0]    frame_seq,
	input  logic [gbn_pkg::TAG_W-1:0]    frame_tag,
	input  logic [gbn_pkg::LEN_W-1:0]    frame_length,
	input  logic [gbn_pkg::SEQ_W-1:0]    ack_number,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [gbn_pkg::SEQ_W-1:0]    out_seq,
	output logic [gbn_pkg::TAG_W-1:0]    out_tag,
	output logic [gbn_pkg::LEN_W-1:0]    out_length,
	output logic                         dropped,
	output logic                         last
);

	localparam int CW  = $clog2(WINDOW_DEPTH + 1);
	localparam int LW  = (CW > gbn_pkg::LIMIT_W) ? CW : gbn_pkg::LIMIT_W;
	localparam int NW  = $clog2(PENDING_DEPTH + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RETIRE = 3'd1;
	localparam logic [2:0] ST_REFILL = 3'd2;
	localparam logic [2:0] ST_EMIT   = 3'd3;
	localparam logic [2:0] ST_ROTATE = 3'd4;
	localparam logic [2:0] ST_DROP   = 3'd5;

	logic [2:0]                  state_q;
	logic [gbn_pkg::LIMIT_W-1:0] limit_q;
	logic [CW-1:0]               win_count_q;
	logic [CW-1:0]               rot_q;
	logic [gbn_pkg::SEQ_W-1:0]   ack_q;
	logic                        drop_q;
	logic                        emitted_q;

	logic                        out_valid_q;
	gbn_pkg::frame_t             out_frame_q;
	logic                        dropped_q;
	logic                        last_q;

	logic                        accept;
	logic                        out_free;
	logic                        out_load;
	gbn_pkg::frame_t             out_frame_d;
	logic                        dropped_d;
	logic                        last_d;

	logic [LW-1:0]               lim;
	logic [LW:0]                 win_ext;
	logic                        can_refill;
	logic                        retire_hit;

	gbn_pkg::win_ctrl_t          ctrl;
	gbn_pkg::frame_t             win_frame [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0]     win_valid;

	logic                        fifo_wr;
	logic                        fifo_rd;
	gbn_pkg::frame_t             fifo_wr_data;
	gbn_pkg::frame_t             fifo_rd_data;
	logic [NW-1:0]               pend_count;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Limit register values 0 and above the depth are clamped
	always_comb begin
		if (limit_q == '0) begin
			lim = LW'(1);
		end else if (LW'(limit_q) > LW'(WINDOW_DEPTH)) begin
			lim = LW'(WINDOW_DEPTH);
		end else begin
			lim = LW'(limit_q);
		end
	end

	assign win_ext    = (LW + 1)'(win_count_q);
	assign can_refill = (win_ext < {1'b0, lim}) && (pend_count != '0);
	assign retire_hit = win_valid[0] && (win_frame[0].seq <= ack_q);

	assign fifo_wr_data = '{seq: frame_seq, tag: frame_tag, len: frame_length};
	assign fifo_wr      = accept && (action == gbn_pkg::ACT_SEND)
	                      && (pend_count != NW'(PENDING_DEPTH));
	assign fifo_rd      = (state_q == ST_REFILL) && can_refill;

	// Sequencer outputs
	always_comb begin
		ctrl        = '0;
		out_load    = 1'b0;
		out_frame_d = fifo_rd_data;
		dropped_d   = drop_q;
		last_d      = 1'b0;
		unique case (state_q)
			ST_RETIRE: begin
				ctrl.shift = retire_hit;
			end
			ST_EMIT: begin
				out_load    = out_free;
				ctrl.append = out_free;
				last_d      = (win_ext + 1'b1 >= {1'b0, lim}) || (pend_count == '0);
			end
			ST_ROTATE: begin
				out_load    = out_free;
				ctrl.shift  = out_free;
				ctrl.recirc = 1'b1;
				out_frame_d = win_frame[0];
				dropped_d   = 1'b0;
				last_d      = (rot_q + CW'(1)) == win_count_q;
			end
			ST_DROP: begin
				out_load    = out_free;
				out_frame_d = '0;
				dropped_d   = 1'b1;
				last_d      = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= gbn_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_count_q <= '0;
			rot_q       <= '0;
			drop_q      <= 1'b0;
			emitted_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					emitted_q <= 1'b0;
					rot_q     <= '0;
					if (accept) begin
						priority case (action)
							gbn_pkg::ACT_SEND: begin
								drop_q  <= (pend_count == NW'(PENDING_DEPTH));
								state_q <= ST_REFILL;
							end
							gbn_pkg::ACT_TIMEOUT: begin
								if (win_count_q != '0) begin
									state_q <= ST_ROTATE;
								end
							end
							gbn_pkg::ACT_ACK: begin
								drop_q  <= 1'b0;
								state_q <= ST_RETIRE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RETIRE: begin
					if (retire_hit) begin
						win_count_q <= win_count_q - 1'b1;
					end else begin
						state_q <= ST_REFILL;
					end
				end
				ST_REFILL: begin
					if (can_refill) begin
						state_q <= ST_EMIT;
					end else if (drop_q && !emitted_q) begin
						state_q <= ST_DROP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						win_count_q <= win_count_q + 1'b1;
						emitted_q   <= 1'b1;
						state_q     <= ST_REFILL;
					end
				end
				ST_ROTATE: begin
					if (out_free) begin
						rot_q <= rot_q + 1'b1;
						if (last_d) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DROP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ack_q <= ack_number;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_frame_q <= out_frame_d;
			dropped_q   <= dropped_d;
			last_q      <= last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_seq    = out_frame_q.seq;
	assign out_tag    = out_frame_q.tag;
	assign out_length = out_frame_q.len;
	assign dropped    = dropped_q;
	assign last       = last_q;

	gbn_pend_fifo #(
		.DEPTH (PENDING_DEPTH)
	) u_pend (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fifo_wr),
		.wr_data (fifo_wr_data),
		.rd_en   (fifo_rd),
		.rd_data (fifo_rd_data),
		.count   (pend_count)
	);

	// Window chain, cell 0 holds the oldest outstanding frame
	for (genvar j = 0; j < WINDOW_DEPTH; j++) begin : g_cell
		logic            prev_v;
		logic            next_v;
		gbn_pkg::frame_t next_f;

		if (j == 0) begin : g_first
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_v = win_valid[j-1];
		end

		if (j == WINDOW_DEPTH - 1) begin : g_top
			assign next_v = 1'b0;
			assign next_f = '0;
		end else begin : g_below
			assign next_v = win_valid[j+1];
			assign next_f = win_frame[j+1];
		end

		gbn_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.prev_valid   (prev_v),
			.next_valid   (next_v),
			.next_frame   (next_f),
			.head_frame   (win_frame[0]),
			.append_frame (fifo_rd_data),
			.valid        (win_valid[j]),
			.frame        (win_frame[j])
		);
	end

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(win_valid) == int'(win_count_q))
		else $error("window count disagrees with cell valid bits");

	a_append_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.append |-> win_count_q < CW'(WINDOW_DEPTH))
		else $error("append into a full window");

	a_rotate_restores: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROTATE) |-> (rot_q < win_count_q))
		else $error("rotation ran past the outstanding frames");

	a_idle_no_output_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !out_load && !fifo_rd && (ctrl == '0))
		else $error("window or output activity while idle");

endmodule

@@ tb/gbn_sender_checker.sv @@
// Go-back-N sender checker: watches the config port and both channels, keeps its own
// copy of the window and the pending queue, and compares every transmit command.
// Depends on gbn_pkg.
`timescale 1ns / 1ps
module gbn_sender_checker #(
	parameter int WIN_DEPTH  = gbn_pkg::WINDOW_DEPTH_DEF,
	parameter int PEND_DEPTH = gbn_pkg::PENDING_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [gbn_pkg::LIMIT_W-1:0]  cfg_wr_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic [gbn_pkg::SEQ_W-1:0]    frame_seq,
	input  logic [gbn_pkg::TAG_W-1:0]    frame_tag,
	input  logic [gbn_pkg::LEN_W-1:0]    frame_length,
	input  logic [gbn_pkg::SEQ_W-1:0]    ack_number,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [gbn_pkg::SEQ_W-1:0]    out_seq,
	input  logic [gbn_pkg::TAG_W-1:0]    out_tag,
	input  logic [gbn_pkg::LEN_W-1:0]    out_length,
	input  logic                         dropped,
	input  logic                         last,
	output int                           mismatches,
	output int                           results_due,
	output int                           xmits_checked,
	output int                           drops_seen
);
	import gbn_pkg::*;

	// expected transmit ring, far deeper than the block can ever owe
	localparam int XQ_DEPTH = 64;

	typedef struct packed {
		frame_t fr;
		logic   dropped;
		logic   last;
	} xmit_t;

	frame_t               win_frames[WIN_DEPTH];
	int                   win_fill;
	frame_t               backlog[PEND_DEPTH];
	int                   bl_head;
	int                   bl_cnt;
	logic [LIMIT_W-1:0]   limit_reg;
	xmit_t                xq_mem[XQ_DEPTH];
	int                   xq_rd;
	int                   xq_wr;
	int                   xq_cnt;
	xmit_t                step_out[WIN_DEPTH];
	int                   step_n;
	int                   err_cnt = 0;
	int                   xmit_cnt = 0;
	int                   drop_cnt = 0;

	// 0 behaves as 1, anything above the window depth as the depth
	function automatic int active_limit();
		int lim;
		lim = int'(limit_reg);
		if (lim < 1)
			lim = 1;
		if (lim > WIN_DEPTH)
			lim = WIN_DEPTH;
		return lim;
	endfunction

	task automatic refill_window();
		while (win_fill < active_limit() && bl_cnt > 0) begin
			win_frames[win_fill] = backlog[bl_head];
			bl_head = (bl_head + 1) % PEND_DEPTH;
			bl_cnt--;
			step_out[step_n].fr = win_frames[win_fill];
			step_out[step_n].dropped = 1'b0;
			step_out[step_n].last = 1'b0;
			step_n++;
			win_fill++;
		end
	endtask

	task automatic predict_transaction(input logic [1:0] act, input frame_t fr,
			input logic [SEQ_W-1:0] ackn);
		int  n;
		bit  refused;
		step_n = 0;
		refused = 1'b0;
		case (act)
			ACT_SEND: begin
				refused = bl_cnt >= PEND_DEPTH;
				if (!refused) begin
					backlog[(bl_head + bl_cnt) % PEND_DEPTH] = fr;
					bl_cnt++;
				end
				refill_window();
				if (refused) begin
					if (step_n == 0) begin
						step_out[0].fr = '0;
						step_out[0].dropped = 1'b1;
						step_out[0].last = 1'b0;
						step_n = 1;
					end else begin
						for (int i = 0; i < step_n; i++)
							step_out[i].dropped = 1'b1;
					end
				end
			end
			ACT_TIMEOUT: begin
				for (int i = 0; i < win_fill; i++) begin
					step_out[i].fr = win_frames[i];
					step_out[i].dropped = 1'b0;
					step_out[i].last = 1'b0;
				end
				step_n = win_fill;
			end
			ACT_ACK: begin
				// cumulative ack retires from the front, plain unsigned compare
				n = 0;
				while (n < win_fill && win_frames[n].seq <= ackn)
					n++;
				for (int i = 0; i + n < win_fill; i++)
					win_frames[i] = win_frames[i + n];
				win_fill -= n;
				refill_window();
			end
			default: ;
		endcase
		if (step_n > 0)
			step_out[step_n - 1].last = 1'b1;
		for (int i = 0; i < step_n; i++) begin
			xq_mem[xq_wr] = step_out[i];
			xq_wr = (xq_wr + 1) % XQ_DEPTH;
			xq_cnt++;
		end
	endtask

	task automatic check_field(input string name, input logic [SEQ_W-1:0] exp_v,
			input logic [SEQ_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s expected %h, got %h", $time, name, exp_v, got_v);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin
		xmit_t want;
		frame_t fr;
		if (!arst_n) begin
			win_fill = 0;
			bl_head = 0;
			bl_cnt = 0;
			xq_rd = 0;
			xq_wr = 0;
			xq_cnt = 0;
			limit_reg = LIMIT_RESET;
		end else begin
			// an output here always belongs to an earlier transaction
			if (out_valid && !out_stall) begin
				xmit_cnt++;
				if (dropped === 1'b1)
					drop_cnt++;
				if (xq_cnt == 0) begin
					$display("%0t: transmit with none expected, seq %h tag %h len %h",
						$time, out_seq, out_tag, out_length);
					err_cnt++;
				end else begin
					want = xq_mem[xq_rd];
					xq_rd = (xq_rd + 1) % XQ_DEPTH;
					xq_cnt--;
					check_field("out_seq", want.fr.seq, out_seq);
					check_field("out_tag", SEQ_W'(want.fr.tag), SEQ_W'(out_tag));
					check_field("out_length", SEQ_W'(want.fr.len), SEQ_W'(out_length));
					check_field("dropped", SEQ_W'(want.dropped), SEQ_W'(dropped));
					check_field("last", SEQ_W'(want.last), SEQ_W'(last));
				end
			end
			if (cfg_wr_en)
				limit_reg = cfg_wr_data;
			if (in_valid && !in_stall) begin
				fr.seq = frame_seq;
				fr.tag = frame_tag;
				fr.len = frame_length;
				predict_transaction(action, fr, ack_number);
			end
		end
		results_due <= xq_cnt;
		mismatches <= err_cnt;
		xmits_checked <= xmit_cnt;
		drops_seen <= drop_cnt;
	end

endmodule

@@ tb/tb_go_back_n_sender_core.sv @@
// Testbench top for go_back_n_sender_core: clock, reset, stimulus, output stalls,
// watchdog and verdict. Depends on gbn_pkg, go_back_n_sender_core and gbn_sender_checker.
`timescale 1ns / 1ps
module tb_go_back_n_sender_core;
	import gbn_pkg::*;

	localparam logic [1:0] ACT_IGNORED = 2'd3;
	localparam int QUIET_LIMIT = 3000;
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_ITEMS = 36;
	localparam int LONG_HOLD   = 400;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [LIMIT_W-1:0]   cfg_wr_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           action;
	logic [SEQ_W-1:0]     frame_seq;
	logic [TAG_W-1:0]     frame_tag;
	logic [LEN_W-1:0]     frame_length;
	logic [SEQ_W-1:0]     ack_number;
	logic                 out_valid;
	logic                 out_stall;
	logic [SEQ_W-1:0]     out_seq;
	logic [TAG_W-1:0]     out_tag;
	logic [LEN_W-1:0]     out_length;
	logic                 dropped;
	logic                 last;

	int                   mismatches;
	int                   results_due;
	int                   xmits_checked;
	int                   drops_seen;

	int                   n_offered = 0;
	int                   n_ignored = 0;
	bit                   calm = 1'b0;
	bit                   long_hold_req = 1'b0;
	logic [SEQ_W-1:0]     next_seq;
	logic [SEQ_W-1:0]     ack_floor;

	always #5 clk = ~clk;

	go_back_n_sender_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.frame_seq    (frame_seq),
		.frame_tag    (frame_tag),
		.frame_length (frame_length),
		.ack_number   (ack_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_seq      (out_seq),
		.out_tag      (out_tag),
		.out_length   (out_length),
		.dropped      (dropped),
		.last         (last)
	);

	gbn_sender_checker watcher (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.frame_seq     (frame_seq),
		.frame_tag     (frame_tag),
		.frame_length  (frame_length),
		.ack_number    (ack_number),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_seq       (out_seq),
		.out_tag       (out_tag),
		.out_length    (out_length),
		.dropped       (dropped),
		.last          (last),
		.mismatches    (mismatches),
		.results_due   (results_due),
		.xmits_checked (xmits_checked),
		.drops_seen    (drops_seen)
	);

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	task automatic offer(input logic [1:0] act, input logic [SEQ_W-1:0] s,
			input logic [TAG_W-1:0] t, input logic [LEN_W-1:0] l,
			input logic [SEQ_W-1:0] a);
		action <= act;
		frame_seq <= s;
		frame_tag <= t;
		frame_length <= l;
		ack_number <= a;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (act == ACT_IGNORED)
			n_ignored++;
		else
			n_offered++;
	endtask

	task automatic idle_gap();
		int g;
		g = calm ? 0 : pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// frames that cause nothing may still be in flight, hence the tail
	task automatic wait_until_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		wait_until_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_next();
		logic [LEN_W-1:0] l;
		l = ($urandom_range(0, 99) < 5) ? LEN_W'($urandom_range(113, 127))
			: LEN_W'($urandom_range(0, 112));
		offer(ACT_SEND, next_seq, TAG_W'($urandom), l, SEQ_W'($urandom));
		next_seq = next_seq + SEQ_W'($urandom_range(1, 3));
	endtask

	task automatic random_item(input int ack_pct);
		int               r;
		logic [SEQ_W-1:0] a;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0)
			calm = !calm;
		if (r < 15) begin
			// noise: any action, any field values
			offer(2'($urandom_range(0, 3)), SEQ_W'($urandom), TAG_W'($urandom),
				LEN_W'($urandom_range(0, 127)), SEQ_W'($urandom));
		end else begin
			r = $urandom_range(0, 99);
			if (r < ack_pct) begin
				if ($urandom_range(0, 9) == 0) begin
					a = ack_floor - SEQ_W'($urandom_range(0, 4));
				end else begin
					a = ack_floor + SEQ_W'($urandom_range(0, 5));
					ack_floor = a;
				end
				offer(ACT_ACK, SEQ_W'($urandom), TAG_W'($urandom), LEN_W'($urandom), a);
			end else if (r < ack_pct + 10) begin
				offer(ACT_TIMEOUT, SEQ_W'($urandom), TAG_W'($urandom), LEN_W'($urandom),
					SEQ_W'($urandom));
			end else if (r < ack_pct + 13) begin
				offer(ACT_IGNORED, SEQ_W'($urandom), TAG_W'($urandom), LEN_W'($urandom),
					SEQ_W'($urandom));
			end else begin
				send_next();
			end
		end
		idle_gap();
	endtask

	// receiver: random stall runs, quiet stretches, one long hold-off
	initial begin : receiver
		int hold_left;
		int run_left;
		bit stalling;
		bit hold_used;
		hold_left = 0;
		run_left = 0;
		stalling = 1'b0;
		hold_used = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !hold_used) begin
				hold_used = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					stalling = $urandom_range(0, 99) < 35;
					run_left = stalling ? pick_gap() + 1 : $urandom_range(1, 12);
				end
				run_left--;
				out_stall <= stalling;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		int limit_plan[8];
		int ack_pct;
		int start_cnt;
		limit_plan = '{0, 3, 7, 5, 6, 1, 4, 2};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		action = ACT_SEND;
		frame_seq = '0;
		frame_tag = '0;
		frame_length = '0;
		ack_number = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing outstanding yet: timeout, ignored action, ack all produce nothing
		offer(ACT_TIMEOUT, '0, '0, '0, '0);
		offer(ACT_IGNORED, '1, '1, '1, '1);
		offer(ACT_ACK, '0, '0, '0, '0);

		// window of one: first frame goes out, the next sixteen fill the backlog
		write_limit(LIMIT_W'(1));
		offer(ACT_SEND, '0, '0, '0, '1);
		idle_gap();
		offer(ACT_SEND, 32'd5, 6'd21, 7'd112, '0);
		offer(ACT_SEND, '1, '1, '1, '0);
		idle_gap();
		offer(ACT_SEND, 32'd7, 6'd42, 7'd1, '0);
		for (int i = 4; i <= 16; i++) begin
			offer(ACT_SEND, SEQ_W'(100 + i), TAG_W'($urandom), LEN_W'($urandom_range(0, 112)),
				SEQ_W'($urandom));
			idle_gap();
		end
		// backlog full, window full: refused with a bare drop flag
		offer(ACT_SEND, 32'h200, 6'h2a, 7'd64, '0);
		offer(ACT_TIMEOUT, '0, '0, '0, '0);
		offer(ACT_ACK, '0, '0, '0, 32'd6);
		offer(ACT_SEND, 32'h300, 6'h15, 7'd33, '0);
		// room in the window but backlog full: refill goes out flagged as dropped
		write_limit(LIMIT_W'(4));
		offer(ACT_SEND, 32'h400, 6'h3f, 7'd100, '0);
		// limit below the outstanding count: retire one, no refill
		write_limit(LIMIT_W'(2));
		offer(ACT_ACK, '0, '0, '0, 32'd5);
		offer(ACT_ACK, '0, '0, '0, '1);

		next_seq = SEQ_W'($urandom_range(0, 32'h0fffffff));
		ack_floor = next_seq;
		foreach (limit_plan[p]) begin
			write_limit(LIMIT_W'(limit_plan[p]));
			calm = 1'b0;
			ack_pct = $urandom_range(5, 35);
			next_seq = next_seq + SEQ_W'($urandom_range(0, 1000));
			start_cnt = n_offered;
			if (p == 2) begin
				// hold the output off while sends keep coming back to back
				long_hold_req = 1'b1;
				repeat (30) send_next();
			end
			while (n_offered - start_cnt < PHASE_ITEMS)
				random_item(ack_pct);
		end

		wait_until_idle();
		$display("covered %0d transactions plus %0d ignored, %0d transmit commands checked",
			n_offered, n_ignored, xmits_checked);
		$display("%0d drop flags seen, window limits 0..7, one long output hold-off",
			drops_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
